### sv/population_rate_monitor_with_loss_core_macros.svh
// ----------------------------------------------------------------------------
// population rate monitor assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef POPULATION_RATE_MONITOR_WITH_LOSS_CORE_MACROS_SVH
`define POPULATION_RATE_MONITOR_WITH_LOSS_CORE_MACROS_SVH

// assertion sampled on the rising edge, switched off while reset is high
`define PRM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assertion sampled on the rising edge, also checked during reset
`define PRM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/prm_pkg.sv
// ----------------------------------------------------------------------------
// prm_pkg
// types, constants and helpers shared by the rate monitor files
// ----------------------------------------------------------------------------
package prm_pkg;

  // field widths
  localparam int RATE_W     = 32;
  localparam int LOSS_W     = 64;
  localparam int DECAY_W    = 24;
  localparam int GAIN_W     = 32;
  localparam int COUNT_W    = 13;
  localparam int IDX_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int DEN_W      = RATE_W + 1;
  localparam int PROD_W     = 2 * RATE_W;

  // fixed point shifts
  localparam int DECAY_SHIFT = 24;
  localparam int GAIN_SHIFT  = 8;

  // serial divider: quotient bits per cycle and iteration count
  localparam int DIV_BITS   = 2;
  localparam int DIV_ITERS  = LOSS_W / DIV_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_ITERS);

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_RATE     = 3'd0,
    REG_MAX_RATE     = 3'd1,
    REG_TARGET_RATE  = 3'd2,
    REG_DECAY_FACTOR = 3'd3,
    REG_SPIKE_GAIN   = 3'd4,
    REG_LOSS_OFFSET  = 3'd5
  } prm_reg_t;

  // input commands
  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  // register reset values
  localparam logic [RATE_W-1:0]  MIN_RATE_RST     = 32'd0;
  localparam logic [RATE_W-1:0]  MAX_RATE_RST     = 32'd6553600;
  localparam logic [RATE_W-1:0]  TARGET_RATE_RST  = 32'd327680;
  localparam logic [DECAY_W-1:0] DECAY_FACTOR_RST = 24'd16775537;
  localparam logic [GAIN_W-1:0]  SPIKE_GAIN_RST   = 32'd16777;
  localparam logic [RATE_W-1:0]  LOSS_OFFSET_RST  = 32'd131072;

  // rate after reset: midpoint of the reset bounds
  localparam logic [DEN_W-1:0]   BOUND_SUM_RST =
    {1'b0, MIN_RATE_RST} + {1'b0, MAX_RATE_RST};
  localparam logic [RATE_W-1:0]  RATE_RST = BOUND_SUM_RST[DEN_W-1:1];

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECAY,
    S_INC,
    S_SUM,
    S_CHECK,
    S_SQUARE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_ACC,
    S_DONE
  } prm_state_t;

  // divider request and response
  typedef struct packed {
    logic               start;
    logic [LOSS_W-1:0]  dividend;
    logic [DEN_W-1:0]   divisor;
  } prm_div_req_t;

  typedef struct packed {
    logic               done;
    logic [LOSS_W-1:0]  quotient;
  } prm_div_rsp_t;

  // one restoring division step: returns {new remainder, quotient bit}
  function automatic logic [DEN_W:0] prm_div_step(
    input logic [DEN_W-1:0] rem,
    input logic             din,
    input logic [DEN_W-1:0] den
  );
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    trial = {rem, din};
    diff  = trial - {1'b0, den};
    if (trial >= {1'b0, den}) begin
      return {diff[DEN_W-1:0], 1'b1};
    end else begin
      return {trial[DEN_W-1:0], 1'b0};
    end
  endfunction

endpackage

### sv/prm_item_if.sv
// ----------------------------------------------------------------------------
// prm_item_if
// input channel of the rate monitor: one tick or restart per transaction
// ----------------------------------------------------------------------------
interface prm_item_if;
  logic                              valid;
  logic                              ready;
  logic                              cmd;
  logic [prm_pkg::COUNT_W-1:0]       spike_count;
  logic                              score_enable;

  modport source (output valid, cmd, spike_count, score_enable, input ready);
  modport sink   (input valid, cmd, spike_count, score_enable, output ready);
endinterface

### sv/prm_result_if.sv
// ----------------------------------------------------------------------------
// prm_result_if
// output channel of the rate monitor: one status record per transaction
// ----------------------------------------------------------------------------
interface prm_result_if;
  logic                              valid;
  logic                              ready;
  logic [prm_pkg::RATE_W-1:0]        rate;
  logic                              in_range;
  logic [prm_pkg::LOSS_W-1:0]        loss_total;
  logic [prm_pkg::IDX_W-1:0]         tick_index;

  modport source (output valid, rate, in_range, loss_total, tick_index, input ready);
  modport sink   (input valid, rate, in_range, loss_total, tick_index, output ready);
endinterface

### sv/prm_divider.sv
// ----------------------------------------------------------------------------
// prm_divider
// serial restoring divider, 64-bit dividend by 33-bit divisor, two bits a cycle
// ----------------------------------------------------------------------------
module prm_divider (
  input  logic                  clk,
  input  logic                  rst,
  input  prm_pkg::prm_div_req_t req,
  output prm_pkg::prm_div_rsp_t rsp
);

  logic                            busy;
  logic                            done;
  logic [prm_pkg::DIV_CNT_W-1:0]   cnt;
  logic [prm_pkg::DEN_W-1:0]       rem;
  logic [prm_pkg::LOSS_W-1:0]      work;
  logic [prm_pkg::DEN_W-1:0]       den;
  logic [prm_pkg::DEN_W-1:0]       rem_next;
  logic [prm_pkg::LOSS_W-1:0]      work_next;

  // two restoring steps; dividend bits leave at the top, quotient bits enter below
  always_comb begin
    logic [prm_pkg::DEN_W:0] s;
    rem_next  = rem;
    work_next = work;
    for (int i = 0; i < prm_pkg::DIV_BITS; i++) begin
      s         = prm_pkg::prm_div_step(rem_next, work_next[prm_pkg::LOSS_W-1], den);
      rem_next  = s[prm_pkg::DEN_W:1];
      work_next = {work_next[prm_pkg::LOSS_W-2:0], s[0]};
    end
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == prm_pkg::DIV_CNT_W'(prm_pkg::DIV_ITERS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // operand and partial result registers
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= '0;
      work <= req.dividend;
      den  <= req.divisor;
    end else if (busy) begin
      rem  <= rem_next;
      work <= work_next;
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = work;

endmodule

### sv/population_rate_monitor_with_loss_core.sv
// ----------------------------------------------------------------------------
// population_rate_monitor_with_loss_core
// leaky integrator population rate monitor with range flag and loss score
// ----------------------------------------------------------------------------
// One transaction at a time: a tick runs the decay, increment, sum and check
// states to a loaded result when no loss is scored, and the square, divider
// start, divider wait and accumulate states too when the loss term is added,
// the serial divider giving 2 quotient bits per cycle; a restart goes to check.
// All multiplies share one 32x32 multiplier with a registered product. The
// result sits in an output register, so the next transaction is taken while a
// result still waits. Register writes belong in idle time and apply from the
// next transaction; the rate moves to a new bound midpoint only on a restart.
module population_rate_monitor_with_loss_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [prm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [prm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  prm_item_if.sink                        item,
  prm_result_if.source                    result
);

  // configuration registers
  logic [prm_pkg::RATE_W-1:0]   min_rate;
  logic [prm_pkg::RATE_W-1:0]   max_rate;
  logic [prm_pkg::RATE_W-1:0]   target_rate;
  logic [prm_pkg::DECAY_W-1:0]  decay_factor;
  logic [prm_pkg::GAIN_W-1:0]   spike_gain;
  logic [prm_pkg::RATE_W-1:0]   loss_offset;

  // architectural state
  logic [prm_pkg::RATE_W-1:0]   rate;
  logic [prm_pkg::LOSS_W-1:0]   loss;
  logic [prm_pkg::IDX_W-1:0]    tick_counter;

  // per transaction registers
  prm_pkg::prm_state_t          state;
  prm_pkg::prm_state_t          state_next;
  logic                         cmd;
  logic [prm_pkg::COUNT_W-1:0]  spike_count;
  logic                         score_enable;
  logic [prm_pkg::IDX_W-1:0]    tick_index;
  logic                         in_range;
  logic [prm_pkg::RATE_W-1:0]   decayed;
  logic [prm_pkg::RATE_W-1:0]   diff;
  logic [prm_pkg::DEN_W-1:0]    den;
  logic [prm_pkg::PROD_W-1:0]   prod;

  // output register
  logic                         out_valid;
  logic [prm_pkg::RATE_W-1:0]   out_rate;
  logic                         out_in_range;
  logic [prm_pkg::LOSS_W-1:0]   out_loss;
  logic [prm_pkg::IDX_W-1:0]    out_tick_index;

  // sequencer outputs
  logic                         accept;
  logic                         out_free;
  logic                         out_load;
  logic                         prod_load;
  logic [prm_pkg::RATE_W-1:0]   mul_a;
  logic [prm_pkg::RATE_W-1:0]   mul_b;
  prm_pkg::prm_div_req_t        div_req;
  prm_pkg::prm_div_rsp_t        div_rsp;

  // datapath helpers
  logic [prm_pkg::DEN_W-1:0]    bound_sum;
  logic [prm_pkg::RATE_W+5:0]   rate_sum;
  logic [prm_pkg::LOSS_W:0]     loss_sum;
  logic [prm_pkg::LOSS_W-1:0]   loss_term;

  // range test on the current rate
  function automatic logic in_range_now();
    return (rate > min_rate) && (rate < max_rate);
  endfunction

  assign accept   = item.valid && item.ready;
  assign out_free = !out_valid || result.ready;

  // configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      min_rate     <= prm_pkg::MIN_RATE_RST;
      max_rate     <= prm_pkg::MAX_RATE_RST;
      target_rate  <= prm_pkg::TARGET_RATE_RST;
      decay_factor <= prm_pkg::DECAY_FACTOR_RST;
      spike_gain   <= prm_pkg::SPIKE_GAIN_RST;
      loss_offset  <= prm_pkg::LOSS_OFFSET_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        prm_pkg::REG_MIN_RATE:     min_rate     <= cfg_wdata;
        prm_pkg::REG_MAX_RATE:     max_rate     <= cfg_wdata;
        prm_pkg::REG_TARGET_RATE:  target_rate  <= cfg_wdata;
        prm_pkg::REG_DECAY_FACTOR: decay_factor <= cfg_wdata[prm_pkg::DECAY_W-1:0];
        prm_pkg::REG_SPIKE_GAIN:   spike_gain   <= cfg_wdata;
        prm_pkg::REG_LOSS_OFFSET:  loss_offset  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      prm_pkg::S_IDLE: begin
        if (accept) begin
          state_next = (item.cmd == prm_pkg::CMD_RESTART) ? prm_pkg::S_CHECK
                                                          : prm_pkg::S_DECAY;
        end
      end
      prm_pkg::S_DECAY:  state_next = prm_pkg::S_INC;
      prm_pkg::S_INC:    state_next = prm_pkg::S_SUM;
      prm_pkg::S_SUM:    state_next = prm_pkg::S_CHECK;
      prm_pkg::S_CHECK: begin
        if (cmd == prm_pkg::CMD_TICK && score_enable && in_range_now()) begin
          state_next = prm_pkg::S_SQUARE;
        end else begin
          state_next = prm_pkg::S_DONE;
        end
      end
      prm_pkg::S_SQUARE: state_next = prm_pkg::S_DIV_GO;
      prm_pkg::S_DIV_GO: state_next = prm_pkg::S_DIV_WAIT;
      prm_pkg::S_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_next = prm_pkg::S_ACC;
        end
      end
      prm_pkg::S_ACC:    state_next = prm_pkg::S_DONE;
      prm_pkg::S_DONE: begin
        if (out_free) begin
          state_next = prm_pkg::S_IDLE;
        end
      end
      default:           state_next = prm_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs: multiplier operands, divider request, handshakes
  always_comb begin
    item.ready       = 1'b0;
    prod_load        = 1'b0;
    out_load         = 1'b0;
    mul_a            = rate;
    mul_b            = {{(prm_pkg::RATE_W-prm_pkg::DECAY_W){1'b0}}, decay_factor};
    div_req.start    = 1'b0;
    div_req.dividend = prod;
    div_req.divisor  = den;
    case (state)
      prm_pkg::S_IDLE:   item.ready = !rst;
      prm_pkg::S_DECAY:  prod_load  = 1'b1;
      prm_pkg::S_INC: begin
        prod_load = 1'b1;
        mul_a     = {{(prm_pkg::RATE_W-prm_pkg::COUNT_W){1'b0}}, spike_count};
        mul_b     = spike_gain;
      end
      prm_pkg::S_SQUARE: begin
        prod_load = 1'b1;
        mul_a     = diff;
        mul_b     = diff;
      end
      prm_pkg::S_DIV_GO: div_req.start = 1'b1;
      prm_pkg::S_DONE:   out_load = out_free;
      default: ;
    endcase
  end

  // serial divider for the loss term
  prm_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // datapath arithmetic
  assign bound_sum = {1'b0, min_rate} + {1'b0, max_rate};
  assign rate_sum  = {6'd0, decayed}
                   + {1'b0, prod[prm_pkg::GAIN_SHIFT+prm_pkg::RATE_W+4:prm_pkg::GAIN_SHIFT]};
  assign loss_term = (den == '0) ? '0 : div_rsp.quotient;
  assign loss_sum  = {1'b0, loss} + {1'b0, loss_term};

  // sequencer state, architectural state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= prm_pkg::S_IDLE;
      rate         <= prm_pkg::RATE_RST;
      loss         <= '0;
      tick_counter <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (item.cmd == prm_pkg::CMD_RESTART) begin
          rate <= bound_sum[prm_pkg::DEN_W-1:1];
        end else begin
          tick_counter <= tick_counter + 1'b1;
        end
      end
      if (state == prm_pkg::S_SUM) begin
        rate <= (rate_sum[prm_pkg::RATE_W+5:prm_pkg::RATE_W] != '0) ? '1
                                                                   : rate_sum[prm_pkg::RATE_W-1:0];
      end
      if (state == prm_pkg::S_ACC) begin
        loss <= loss_sum[prm_pkg::LOSS_W] ? '1 : loss_sum[prm_pkg::LOSS_W-1:0];
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // per transaction payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd          <= item.cmd;
      spike_count  <= item.spike_count;
      score_enable <= item.score_enable;
      tick_index   <= tick_counter;
    end
    if (prod_load) begin
      prod <= mul_a * mul_b;
    end
    if (state == prm_pkg::S_INC) begin
      decayed <= prod[prm_pkg::DECAY_SHIFT+prm_pkg::RATE_W-1:prm_pkg::DECAY_SHIFT];
    end
    if (state == prm_pkg::S_CHECK) begin
      in_range <= in_range_now();
      diff     <= (rate >= target_rate) ? (rate - target_rate) : (target_rate - rate);
      den      <= {1'b0, rate} + {1'b0, loss_offset};
    end
    if (out_load) begin
      out_rate       <= rate;
      out_in_range   <= in_range;
      out_loss       <= loss;
      out_tick_index <= tick_index;
    end
  end

  assign result.valid      = out_valid;
  assign result.rate       = out_rate;
  assign result.in_range   = out_in_range;
  assign result.loss_total = out_loss;
  assign result.tick_index = out_tick_index;

endmodule

### sv/prm_checker.sv
// ----------------------------------------------------------------------------
// prm_checker
// port level assertions for the rate monitor, bound to the top level
// ----------------------------------------------------------------------------
`include "population_rate_monitor_with_loss_core_macros.svh"

module prm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          item_valid,
  input logic                          item_ready,
  input logic                          result_valid,
  input logic                          result_ready,
  input logic [prm_pkg::RATE_W-1:0]    rate,
  input logic                          in_range,
  input logic [prm_pkg::LOSS_W-1:0]    loss_total,
  input logic [prm_pkg::IDX_W-1:0]     tick_index
);

  // a pending result stays offered
  `PRM_ASSERT(a_result_hold, clk, rst, result_valid && !result_ready |=> result_valid, "result dropped while stalled")

  // a stalled result keeps its payload
  `PRM_ASSERT(a_payload_hold, clk, rst, result_valid && !result_ready |=> $stable(rate) && $stable(in_range) && $stable(loss_total) && $stable(tick_index), "result payload changed while stalled")

  // the sequencer is busy right after taking a transaction
  `PRM_ASSERT(a_busy_after_accept, clk, rst, item_valid && item_ready |=> !item_ready, "second transaction taken back to back")

  // an in-range rate lies above a bound of at least zero
  `PRM_ASSERT(a_range_nonzero, clk, rst, result_valid && in_range |-> rate != '0, "zero rate flagged in range")

  // reset leaves no result pending
  `PRM_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !result_valid, "result valid after reset")

endmodule

bind population_rate_monitor_with_loss_core prm_checker u_prm_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .rate         (result.rate),
  .in_range     (result.in_range),
  .loss_total   (result.loss_total),
  .tick_index   (result.tick_index)
);

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the population rate monitor. Ticks and restarts go
// in over the item channel. A scoreboard predicts each status record (decayed
// rate, range flag, saturating loss, tick number) and checks it against the
// result channel. The run walks through several register settings and
// handshake stall patterns.
// ----------------------------------------------------------------------------
module tb;
  import prm_pkg::*;

  localparam int ITEMS_PER_PHASE = 154;
  localparam int N_PHASES        = 8;
  localparam int SETTLE_CYCLES   = 48;
  localparam int MAX_COUNT       = 8191;

  // register slots past the last real one, writes there are dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic               cmd;
    logic [COUNT_W-1:0] spike_count;
    logic               score_enable;
  } tick_item_t;

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic              in_range;
    logic [LOSS_W-1:0] loss_total;
    logic [IDX_W-1:0]  tick_index;
  } rate_status_t;

  // predicts status records and checks them in order
  class rate_scoreboard;
    logic [RATE_W-1:0]  lo_bound;
    logic [RATE_W-1:0]  hi_bound;
    logic [RATE_W-1:0]  target;
    logic [DECAY_W-1:0] decay;
    logic [GAIN_W-1:0]  gain;
    logic [RATE_W-1:0]  offset;
    logic [RATE_W-1:0]  level;
    logic [LOSS_W-1:0]  loss;
    logic [IDX_W-1:0]   tick_no;
    rate_status_t       expected_status_q[$];
    int                 error_count;

    function new();
      lo_bound    = MIN_RATE_RST;
      hi_bound    = MAX_RATE_RST;
      target      = TARGET_RATE_RST;
      decay       = DECAY_FACTOR_RST;
      gain        = SPIKE_GAIN_RST;
      offset      = LOSS_OFFSET_RST;
      level       = RATE_RST;
      loss        = '0;
      tick_no     = '0;
      error_count = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MIN_RATE:     lo_bound = data;
        REG_MAX_RATE:     hi_bound = data;
        REG_TARGET_RATE:  target   = data;
        REG_DECAY_FACTOR: decay    = data[DECAY_W-1:0];
        REG_SPIKE_GAIN:   gain     = data;
        REG_LOSS_OFFSET:  offset   = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_status_q.size();
    endfunction

    // one tick or restart applied to the rate, loss and tick number
    function rate_status_t predict_status(tick_item_t it);
      logic [63:0]       decayed;
      logic [63:0]       gained;
      logic [63:0]       total;
      logic [RATE_W-1:0] diff;
      logic [63:0]       sq;
      logic [DEN_W-1:0]  den;
      logic [63:0]       term;
      logic [64:0]       acc;
      logic [DEN_W-1:0]  bound_sum;
      rate_status_t      s;
      if (it.cmd == CMD_RESTART) begin
        bound_sum    = {1'b0, lo_bound} + {1'b0, hi_bound};
        level        = bound_sum[DEN_W-1:1];
        s.in_range   = (level > lo_bound) && (level < hi_bound);
        s.tick_index = tick_no;
      end else begin
        decayed    = (64'(level) * 64'(decay)) >> DECAY_SHIFT;
        gained     = (64'(it.spike_count) * 64'(gain)) >> GAIN_SHIFT;
        total      = decayed + gained;
        level      = (total > 64'hFFFF_FFFF) ? '1 : total[RATE_W-1:0];
        s.in_range = (level > lo_bound) && (level < hi_bound);
        if (s.in_range && it.score_enable) begin
          diff = (level >= target) ? level - target : target - level;
          sq   = 64'(diff) * 64'(diff);
          den  = {1'b0, level} + {1'b0, offset};
          term = (den == '0) ? '0 : sq / 64'(den);
          acc  = {1'b0, loss} + {1'b0, term};
          loss = acc[64] ? '1 : acc[63:0];
        end
        s.tick_index = tick_no;
        tick_no      = tick_no + 1'b1;
      end
      s.rate       = level;
      s.loss_total = loss;
      return s;
    endfunction

    function void note_tick(tick_item_t it);
      expected_status_q.push_back(predict_status(it));
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        error_count++;
      end
    endfunction

    function void check_status(rate_status_t got);
      rate_status_t want;
      if (expected_status_q.size() == 0) begin
        $display("%0t: unexpected status, expected none, actual %0h", $time, got);
        error_count++;
        return;
      end
      want = expected_status_q.pop_front();
      compare_field("rate", 64'(want.rate), 64'(got.rate));
      compare_field("in_range", 64'(want.in_range), 64'(got.in_range));
      compare_field("loss_total", want.loss_total, got.loss_total);
      compare_field("tick_index", 64'(want.tick_index), 64'(got.tick_index));
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  prm_item_if   item_ch();
  prm_result_if result_ch();

  rate_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;

  population_rate_monitor_with_loss_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .item      (item_ch),
    .result    (result_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // result side: check each transaction, stall at random
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      sb.check_status({result_ch.rate, result_ch.in_range,
                       result_ch.loss_total, result_ch.tick_index});
    end
    result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // one input transaction, valid stays high until the next call decides
  task automatic send_item(input logic c, input logic [COUNT_W-1:0] n, input logic s);
    tick_item_t it;
    it = '{cmd: c, spike_count: n, score_enable: s};
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid        <= 1'b1;
    item_ch.cmd          <= c;
    item_ch.spike_count  <= n;
    item_ch.score_enable <= s;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    sb.note_tick(it);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  // wait for the last status record, then let the block settle
  task automatic drain();
    item_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register set of one phase and the spike count range its items favor
  task automatic load_phase_config(input int p, output int cap);
    logic [CFG_DATA_W-1:0] v [6];
    logic [CFG_DATA_W-1:0] lo;
    case (p)
      1: begin
        // fast decay, one rate unit per spike
        v   = '{32'h0001_0000, 32'h0064_0000, 32'h000A_0000,
                32'h0080_0000, 32'h0100_0000, 32'h0};
        cap = 100;
      end
      2: begin
        // every register but the min rate at its top value
        v   = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'h00FF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        v[0] = 32'h0;
        cap = 3;
      end
      3: begin
        // crossed bounds, zero gain and decay
        v   = '{32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
        cap = MAX_COUNT;
      end
      5: begin
        // narrow window around half scale, slow drift
        v   = '{32'h7FFF_0000, 32'h8001_0000, 32'h8000_0000,
                32'h00FF_FFFF, 32'h0000_8000, 32'h0};
        cap = 4;
      end
      4, 7: begin
        // random window, junk above the decay field
        lo   = $urandom_range(0, 32'h00FF_FFFF);
        v[0] = lo;
        v[1] = lo + $urandom_range(1, 32'h00FF_FFFF);
        v[2] = $urandom_range(lo, v[1]);
        v[3] = $urandom;
        v[4] = $urandom_range(0, 32'h0000_FFFF);
        v[5] = $urandom;
        cap  = $urandom_range(1, 2000);
      end
      default: begin
        v   = '{MIN_RATE_RST, MAX_RATE_RST, TARGET_RATE_RST,
                32'(DECAY_FACTOR_RST), SPIKE_GAIN_RST, LOSS_OFFSET_RST};
        cap = (p == 0) ? 2000 : MAX_COUNT;
      end
    endcase
    write_reg(REG_MIN_RATE, v[0]);
    write_reg(REG_MAX_RATE, v[1]);
    write_reg(REG_TARGET_RATE, v[2]);
    write_reg(REG_DECAY_FACTOR, v[3]);
    write_reg(REG_SPIKE_GAIN, v[4]);
    write_reg(REG_LOSS_OFFSET, v[5]);
    if (p == 4) begin
      write_reg(REG_SPARE_LO, $urandom);
      write_reg(REG_SPARE_HI, $urandom);
    end
    cfg_we <= 1'b0;
  endtask

  // stimulus
  initial begin
    int                 cap;
    int                 sel;
    logic               c;
    logic [COUNT_W-1:0] n;
    sb             = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_index            <= '0;
    cfg_wdata            <= '0;
    item_ch.valid        <= 1'b0;
    item_ch.cmd          <= CMD_TICK;
    item_ch.spike_count  <= '0;
    item_ch.score_enable <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: reset rate, full counts up to blow-up, restart recovery
    send_item(CMD_TICK, 13'd0, 1'b0);
    send_item(CMD_TICK, 13'd0, 1'b1);
    send_item(CMD_TICK, 13'd8191, 1'b1);
    send_item(CMD_TICK, 13'd4096, 1'b1);
    repeat (7) send_item(CMD_TICK, 13'd8191, 1'b1);
    send_item(CMD_TICK, 13'd8191, 1'b0);
    send_item(CMD_TICK, 13'd0, 1'b1);
    send_item(CMD_RESTART, 13'd8191, 1'b1);
    send_item(CMD_TICK, 13'd1, 1'b1);
    send_item(CMD_TICK, 13'd2730, 1'b1);
    send_item(CMD_TICK, 13'd5461, 1'b0);
    send_item(CMD_RESTART, 13'd0, 1'b0);
    send_item(CMD_TICK, 13'd0, 1'b1);

    // random phases, each under its own registers and stall pattern
    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      load_phase_config(p, cap);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      // odd phases tick on the old rate first
      if (p % 2 == 0) send_item(CMD_RESTART, COUNT_W'($urandom), 1'($urandom));
      repeat (ITEMS_PER_PHASE) begin
        c   = ($urandom_range(0, 99) < 6) ? CMD_RESTART : CMD_TICK;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
          case ($urandom_range(0, 2))
            0: n = 13'd0;
            1: n = 13'd4096;
            default: n = 13'd8191;
          endcase
        end else if (sel < 3) begin
          n = COUNT_W'($urandom_range(0, MAX_COUNT));
        end else begin
          n = COUNT_W'($urandom_range(0, cap));
        end
        send_item(c, n, $urandom_range(0, 3) != 0);
      end
    end

    drain();
    if (sb.error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
